>>> hdl/ata_pkg.sv
//------------------------------------------------------------------------------
// ATA PIO sequencer package
// Shared types, bus codes and the bus access sequence generator.
//------------------------------------------------------------------------------
`default_nettype none

package ata_pkg;

    // Request types.
    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_FLUSH = 3'd2;
    localparam logic [2:0] REQ_IDENT = 3'd3;
    localparam logic [2:0] REQ_RESP  = 3'd4;
    localparam logic [2:0] REQ_WWORD = 3'd5;

    // Bus operations.
    localparam logic [2:0] BUS_NONE  = 3'd0;
    localparam logic [2:0] BUS_BWR   = 3'd1;
    localparam logic [2:0] BUS_BRD   = 3'd2;
    localparam logic [2:0] BUS_WRD   = 3'd3;
    localparam logic [2:0] BUS_WWR   = 3'd4;

    // Outcomes.
    localparam logic [2:0] OUT_OK      = 3'd0;
    localparam logic [2:0] OUT_REJECT  = 3'd1;
    localparam logic [2:0] OUT_DEVERR  = 3'd2;
    localparam logic [2:0] OUT_TIMEOUT = 3'd3;
    localparam logic [2:0] OUT_NODEV   = 3'd4;

    // Ports.
    localparam logic [9:0] PORT_DATA   = 10'h1F0;
    localparam logic [9:0] PORT_COUNT  = 10'h1F2;
    localparam logic [9:0] PORT_LBA0   = 10'h1F3;
    localparam logic [9:0] PORT_LBA1   = 10'h1F4;
    localparam logic [9:0] PORT_LBA2   = 10'h1F5;
    localparam logic [9:0] PORT_DRIVE  = 10'h1F6;
    localparam logic [9:0] PORT_CMD    = 10'h1F7;
    localparam logic [9:0] PORT_CTRL   = 10'h3F6;

    // Command and status bytes.
    localparam logic [7:0]  CMD_READ   = 8'h20;
    localparam logic [7:0]  CMD_WRITE  = 8'h30;
    localparam logic [7:0]  CMD_FLUSH  = 8'hE7;
    localparam logic [7:0]  CMD_IDENT  = 8'hEC;
    localparam logic [7:0]  DRIVE_LBA  = 8'hE0;
    localparam int          ST_ERR     = 0;
    localparam int          ST_DRQ     = 3;
    localparam int          ST_BSY     = 7;
    localparam logic [31:0] LBA28_MAX  = 32'h0FFF_FFFF;
    localparam logic [23:0] POLL_RESET = 24'd1000000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PROBE,
        PH_WAIT_DRQ,
        PH_DATA_IN,
        PH_WRITE_DATA,
        PH_DISCARD,
        PH_WAIT_DONE
    } phase_t;

    typedef enum logic [2:0] {
        JOB_SINGLE,
        JOB_RW,
        JOB_FLUSH,
        JOB_IDENT,
        JOB_WWEND
    } job_kind_t;

    typedef struct packed {
        logic [2:0]  bus_op;
        logic [9:0]  bus_port;
        logic [15:0] bus_data;
        logic        host_word_valid;
        logic [15:0] host_word;
        logic        done_res;
        logic [2:0]  outcome;
        logic        last;
    } res_t;

    // One queued job: a fully formed result, or a burst that the back end
    // expands. Read/write bursts take their command, and write-end bursts their write word, from res.bus_data.
    typedef struct packed {
        job_kind_t   kind;
        res_t        res;
        logic [27:0] lba;
    } job_t;

    function automatic res_t bus_res(logic [2:0] op, logic [9:0] port, logic [15:0] val);
        res_t r;
        r = '0;
        r.bus_op = op;
        r.bus_port = port;
        r.bus_data = val;
        return r;
    endfunction

    // Index of the final result of a job.
    function automatic logic [2:0] job_end(job_kind_t k);
        logic [2:0] n;
        unique case (k)
            JOB_SINGLE: n = 3'd0;
            JOB_RW:     n = 3'd6;
            JOB_FLUSH:  n = 3'd2;
            JOB_IDENT:  n = 3'd7;
            JOB_WWEND:  n = 3'd1;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic res_t job_res(job_t j, logic [2:0] step);
        res_t r;
        r = bus_res(BUS_BRD, PORT_CMD, 16'h0);
        unique case (j.kind)
            JOB_SINGLE: r = j.res;
            JOB_RW:
                unique case (step)
                    3'd0: r = bus_res(BUS_BWR, PORT_DRIVE, {8'h0, DRIVE_LBA | {4'h0, j.lba[27:24]}});
                    3'd1: r = bus_res(BUS_BWR, PORT_COUNT, 16'h1);
                    3'd2: r = bus_res(BUS_BWR, PORT_LBA0, {8'h0, j.lba[7:0]});
                    3'd3: r = bus_res(BUS_BWR, PORT_LBA1, {8'h0, j.lba[15:8]});
                    3'd4: r = bus_res(BUS_BWR, PORT_LBA2, {8'h0, j.lba[23:16]});
                    3'd5: r = bus_res(BUS_BWR, PORT_CMD, j.res.bus_data);
                    default: r = bus_res(BUS_BRD, PORT_CMD, 16'h0);
                endcase
            JOB_FLUSH:
                unique case (step)
                    3'd0: r = bus_res(BUS_BWR, PORT_DRIVE, {8'h0, DRIVE_LBA});
                    3'd1: r = bus_res(BUS_BWR, PORT_CMD, {8'h0, CMD_FLUSH});
                    default: r = bus_res(BUS_BRD, PORT_CMD, 16'h0);
                endcase
            JOB_IDENT:
                unique case (step)
                    3'd0: r = bus_res(BUS_BWR, PORT_CTRL, 16'h2);
                    3'd1: r = bus_res(BUS_BWR, PORT_DRIVE, {8'h0, DRIVE_LBA});
                    3'd2: r = bus_res(BUS_BWR, PORT_COUNT, 16'h0);
                    3'd3: r = bus_res(BUS_BWR, PORT_LBA0, 16'h0);
                    3'd4: r = bus_res(BUS_BWR, PORT_LBA1, 16'h0);
                    3'd5: r = bus_res(BUS_BWR, PORT_LBA2, 16'h0);
                    3'd6: r = bus_res(BUS_BWR, PORT_CMD, {8'h0, CMD_IDENT});
                    default: r = bus_res(BUS_BRD, PORT_CMD, 16'h0);
                endcase
            JOB_WWEND:
                if (step == 3'd0)
                begin
                    r = bus_res(BUS_WWR, PORT_DATA, j.res.bus_data);
                end
            default: r = j.res;
        endcase
        r.last = (step == job_end(j.kind));
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ata_if.sv
//------------------------------------------------------------------------------
// ATA PIO sequencer channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
//------------------------------------------------------------------------------
`default_nettype none

interface ata_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] lba;
    logic [15:0] data;
    modport source (output valid, req_type, lba, data, input ready);
    modport sink   (input valid, req_type, lba, data, output ready);
endinterface

interface ata_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  bus_op;
    logic [9:0]  bus_port;
    logic [15:0] bus_data;
    logic        host_word_valid;
    logic [15:0] host_word;
    logic        done_res;
    logic [2:0]  outcome;
    logic        last;
    modport source (output valid, bus_op, bus_port, bus_data, host_word_valid, host_word,
                    done_res, outcome, last, input ready);
    modport sink   (input valid, bus_op, bus_port, bus_data, host_word_valid, host_word,
                    done_res, outcome, last, output ready);
endinterface

interface ata_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] poll_limit;
    modport source (output valid, poll_limit, input ready);
    modport sink   (input valid, poll_limit, output ready);
endinterface

`default_nettype wire

>>> hdl/ata_pio_sector_sequencer.sv
//------------------------------------------------------------------------------
// ATA PIO LBA28 sector sequencer
// Host-side engine issuing task-file writes, status polls and data transfers.
//------------------------------------------------------------------------------
// Channel  Direction  Carries
// req      in         req_type, lba, data (commands, bus responses, host words)
// res      out        bus access, host word, completion and outcome
// cfg      in         poll_limit (status reads per wait before timeout)
//
// The front end takes one transfer per cycle while the job queue has room and
// updates the command state at once. The back end issues one result per cycle
// while the result side takes them, and a command's task-file job expands to at
// most eight results (identify: eight). Reset clears the state machine, the queue
// and the output valid flag and loads poll_limit with 1000000. A stalled result
// only holds the front once the four-entry queue fills.
//------------------------------------------------------------------------------
`default_nettype none

module ata_pio_sector_sequencer #(
    parameter int SECTOR_WORDS = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ata_req_if.sink    req,
    ata_res_if.source  res,
    ata_cfg_if.sink    cfg
);

    logic          q_full, q_push, q_pop, q_nempty;
    ata_pkg::job_t q_wr, q_rd;
    ata_pkg::res_t out_res;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    ata_front #(
        .SECTOR_WORDS(SECTOR_WORDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_type      (req.req_type),
        .lba           (req.lba),
        .data          (req.data),
        .cfg_valid     (cfg.valid),
        .cfg_poll_limit(cfg.poll_limit),
        .q_full        (q_full),
        .push          (q_push),
        .job           (q_wr)
    );

    ata_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_job   (q_wr),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_nempty),
        .rd_job   (q_rd)
    );

    ata_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_nempty),
        .q_job    (q_rd),
        .pop      (q_pop),
        .out_valid(res.valid),
        .out_ready(res.ready),
        .out_res  (out_res)
    );

    assign res.bus_op          = out_res.bus_op;
    assign res.bus_port        = out_res.bus_port;
    assign res.bus_data        = out_res.bus_data;
    assign res.host_word_valid = out_res.host_word_valid;
    assign res.host_word       = out_res.host_word;
    assign res.done_res        = out_res.done_res;
    assign res.outcome         = out_res.outcome;
    assign res.last            = out_res.last;

endmodule

`default_nettype wire

>>> hdl/ata_front.sv
//------------------------------------------------------------------------------
// ATA PIO sequencer front end
// Accepts requests, runs the command state machine and queues bus jobs.
//------------------------------------------------------------------------------
`default_nettype none

module ata_front #(
    parameter int SECTOR_WORDS = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire logic [2:0]    req_type,
    input  wire logic [31:0]   lba,
    input  wire logic [15:0]   data,
    input  wire logic          cfg_valid,
    input  wire logic [23:0]   cfg_poll_limit,
    input  wire logic          q_full,
    output logic               push,
    output ata_pkg::job_t      job
);

    localparam int WI_W = $clog2(SECTOR_WORDS + 1);

    ata_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      op_reg, op_next;
    logic [WI_W-1:0] wi_reg, wi_next, wi_inc;
    logic [23:0]     pc_reg, pc_next, pc_inc;
    logic [31:0]     cap_reg, cap_next, cap_upd;
    logic            rdy_reg, rdy_next;
    logic [23:0]     limit_reg;
    logic            acc, err, drq_ok, idle_ok, tmo;

    assign req_ready = !q_full;
    assign acc       = req_valid && !q_full;
    assign wi_inc    = wi_reg + 1'b1;
    assign pc_inc    = pc_reg + 1'b1;
    assign err       = data[ata_pkg::ST_ERR];
    assign idle_ok   = !data[ata_pkg::ST_BSY];
    assign drq_ok    = idle_ok && data[ata_pkg::ST_DRQ];
    assign tmo       = (pc_inc >= limit_reg);

    always_comb
    begin
        cap_upd = cap_reg;
        if (op_reg == ata_pkg::REQ_IDENT[1:0] && 32'(wi_reg) == 32'd60)
        begin
            cap_upd = {cap_reg[31:16], data};
        end
        if (op_reg == ata_pkg::REQ_IDENT[1:0] && 32'(wi_reg) == 32'd61)
        begin
            cap_upd = {data, cap_reg[15:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ata_pkg::PH_IDLE;
            op_reg    <= '0;
            wi_reg    <= '0;
            pc_reg    <= '0;
            cap_reg   <= '0;
            rdy_reg   <= 1'b0;
            limit_reg <= ata_pkg::POLL_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            wi_reg    <= wi_next;
            pc_reg    <= pc_next;
            cap_reg   <= cap_next;
            rdy_reg   <= rdy_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_poll_limit;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        wi_next    = wi_reg;
        pc_next    = pc_reg;
        cap_next   = cap_reg;
        rdy_next   = rdy_reg;
        push       = 1'b0;
        job        = '0;
        job.kind   = ata_pkg::JOB_SINGLE;
        job.lba    = lba[27:0];
        if (acc)
        begin
            if (req_type <= ata_pkg::REQ_IDENT)
            begin
                if (phase_reg == ata_pkg::PH_IDLE)
                begin
                    op_next = req_type[1:0];
                    push    = 1'b1;
                    unique case (req_type)
                        ata_pkg::REQ_READ, ata_pkg::REQ_WRITE:
                            if (!rdy_reg || lba >= cap_reg || lba > ata_pkg::LBA28_MAX)
                            begin
                                job.res.done_res = 1'b1;
                                job.res.outcome  = ata_pkg::OUT_REJECT;
                            end
                            else
                            begin
                                job.kind = ata_pkg::JOB_RW;
                                job.res.bus_data = {8'h0, (req_type == ata_pkg::REQ_READ) ?
                                                   ata_pkg::CMD_READ : ata_pkg::CMD_WRITE};
                                phase_next = ata_pkg::PH_WAIT_DRQ;
                                pc_next    = '0;
                            end
                        ata_pkg::REQ_FLUSH:
                            if (!rdy_reg)
                            begin
                                job.res.done_res = 1'b1;
                                job.res.outcome  = ata_pkg::OUT_REJECT;
                            end
                            else
                            begin
                                job.kind   = ata_pkg::JOB_FLUSH;
                                phase_next = ata_pkg::PH_WAIT_DONE;
                                pc_next    = '0;
                            end
                        default:
                        begin
                            job.kind   = ata_pkg::JOB_IDENT;
                            rdy_next   = 1'b0;
                            cap_next   = '0;
                            phase_next = ata_pkg::PH_PROBE;
                        end
                    endcase
                end
            end
            else if (req_type == ata_pkg::REQ_RESP)
            begin
                unique case (phase_reg)
                    ata_pkg::PH_PROBE:
                    begin
                        push = 1'b1;
                        if (data[7:0] == 8'h0)
                        begin
                            job.res.done_res = 1'b1;
                            job.res.outcome  = ata_pkg::OUT_NODEV;
                            phase_next = ata_pkg::PH_IDLE;
                        end
                        else
                        begin
                            job.res    = ata_pkg::bus_res(ata_pkg::BUS_BRD, ata_pkg::PORT_CMD, 16'h0);
                            phase_next = ata_pkg::PH_WAIT_DRQ;
                            pc_next    = '0;
                        end
                    end
                    ata_pkg::PH_WAIT_DRQ, ata_pkg::PH_WAIT_DONE:
                    begin
                        priority if (err)
                        begin
                            push = 1'b1;
                            job.res.done_res = 1'b1;
                            job.res.outcome  = ata_pkg::OUT_DEVERR;
                            phase_next = ata_pkg::PH_IDLE;
                        end
                        else if (phase_reg == ata_pkg::PH_WAIT_DRQ ? drq_ok : idle_ok)
                        begin
                            if (phase_reg == ata_pkg::PH_WAIT_DONE)
                            begin
                                push = 1'b1;
                                job.res.done_res = 1'b1;
                                job.res.outcome  = ata_pkg::OUT_OK;
                                phase_next = ata_pkg::PH_IDLE;
                            end
                            else
                            begin
                                wi_next = '0;
                                if (op_reg == ata_pkg::REQ_WRITE[1:0])
                                begin
                                    phase_next = ata_pkg::PH_WRITE_DATA;
                                end
                                else
                                begin
                                    push = 1'b1;
                                    job.res = ata_pkg::bus_res(ata_pkg::BUS_WRD,
                                                               ata_pkg::PORT_DATA, 16'h0);
                                    phase_next = ata_pkg::PH_DATA_IN;
                                end
                            end
                        end
                        else
                        begin
                            push    = 1'b1;
                            pc_next = pc_inc;
                            if (tmo)
                            begin
                                job.res.done_res = 1'b1;
                                job.res.outcome  = ata_pkg::OUT_TIMEOUT;
                                phase_next = ata_pkg::PH_IDLE;
                            end
                            else
                            begin
                                job.res = ata_pkg::bus_res(ata_pkg::BUS_BRD,
                                                           ata_pkg::PORT_CMD, 16'h0);
                            end
                        end
                    end
                    ata_pkg::PH_DATA_IN:
                    begin
                        push     = 1'b1;
                        wi_next  = wi_inc;
                        cap_next = cap_upd;
                        if (op_reg != ata_pkg::REQ_IDENT[1:0])
                        begin
                            job.res.host_word_valid = 1'b1;
                            job.res.host_word       = data;
                        end
                        if (wi_inc < WI_W'(SECTOR_WORDS))
                        begin
                            job.res.bus_op   = ata_pkg::BUS_WRD;
                            job.res.bus_port = ata_pkg::PORT_DATA;
                        end
                        else
                        begin
                            job.res.done_res = 1'b1;
                            if (op_reg == ata_pkg::REQ_IDENT[1:0])
                            begin
                                rdy_next = (cap_upd != 32'h0);
                                job.res.outcome = (cap_upd != 32'h0) ?
                                                  ata_pkg::OUT_OK : ata_pkg::OUT_NODEV;
                            end
                            phase_next = ata_pkg::PH_IDLE;
                        end
                    end
                    ata_pkg::PH_DISCARD:
                    begin
                        push       = 1'b1;
                        job.res    = ata_pkg::bus_res(ata_pkg::BUS_BRD, ata_pkg::PORT_CMD, 16'h0);
                        phase_next = ata_pkg::PH_WAIT_DONE;
                        pc_next    = '0;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
            else if (req_type == ata_pkg::REQ_WWORD && phase_reg == ata_pkg::PH_WRITE_DATA)
            begin
                push    = 1'b1;
                wi_next = wi_inc;
                job.res = ata_pkg::bus_res(ata_pkg::BUS_WWR, ata_pkg::PORT_DATA, data);
                if (wi_inc >= WI_W'(SECTOR_WORDS))
                begin
                    job.kind   = ata_pkg::JOB_WWEND;
                    phase_next = ata_pkg::PH_DISCARD;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ata_queue.sv
//------------------------------------------------------------------------------
// ATA PIO sequencer job queue
// Small FIFO of jobs between the front end and the back end.
//------------------------------------------------------------------------------
`default_nettype none

module ata_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ata_pkg::job_t wr_job,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output ata_pkg::job_t      rd_job
);

    localparam int DEPTH = 4;

    ata_pkg::job_t mem_reg [DEPTH];
    logic [1:0]    wp_reg, rp_reg;
    logic [2:0]    cnt_reg;

    assign full      = (cnt_reg == 3'(DEPTH));
    assign not_empty = (cnt_reg != 3'd0);
    assign rd_job    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

`default_nettype wire

>>> hdl/ata_back.sv
//------------------------------------------------------------------------------
// ATA PIO sequencer back end
// Expands queued jobs into bus access results through an output register.
//------------------------------------------------------------------------------
`default_nettype none

module ata_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire ata_pkg::job_t q_job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ata_pkg::res_t      out_res
);

    logic [2:0]    step_reg;
    logic          ov_reg;
    ata_pkg::res_t res_reg;
    logic          load;

    assign load      = q_valid && (!ov_reg || out_ready);
    assign pop       = load && (step_reg == ata_pkg::job_end(q_job.kind));
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= ata_pkg::job_res(q_job, step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ov_reg   <= 1'b1;
                step_reg <= pop ? 3'd0 : step_reg + 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_ata_pio_sector_sequencer.sv
//------------------------------------------------------------------------------
// ATA PIO sector sequencer testbench
// Acts as host and device at once. Items are drawn from the state of a
// built-in model of the sequencer, so that most traffic follows the bus
// protocol. Every result transfer is compared against the model's prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ata_pio_sector_sequencer;
    import ata_pkg::*;

    localparam int SECTOR_WORDS = 256;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 20;

    // Model of the sequencer plus the queue of results it still owes.
    class ata_scoreboard;
        res_t        owed[$];
        phase_t      ph;
        logic [2:0]  op;
        int unsigned widx;
        logic [23:0] pcount;
        logic [23:0] limit;
        logic [31:0] cap;
        bit          rdy;
        int          errors;
        int          checked;
        int          ncmd[4];
        int          nout[8];

        function new();
            ph = PH_IDLE;
            op = REQ_READ;
            widx = 0;
            pcount = '0;
            limit = POLL_RESET;
            cap = '0;
            rdy = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void put(logic [2:0] bop, logic [9:0] port, logic [15:0] val);
            res_t r;
            r = '0;
            r.bus_op = bop;
            r.bus_port = port;
            r.bus_data = val;
            owed.push_back(r);
        endfunction

        function void close(logic [2:0] o);
            res_t r;
            r = '0;
            r.done_res = 1'b1;
            r.outcome = o;
            owed.push_back(r);
            nout[o]++;
            ph = PH_IDLE;
        endfunction

        function void start_wait(phase_t p);
            ph = p;
            pcount = '0;
            put(BUS_BRD, PORT_CMD, 16'h0);
        endfunction

        // Returns 0 to keep polling, 1 when ready, 2 on device error, 3 on timeout.
        function int poll(logic [7:0] s, bit need_drq);
            if (s[ST_ERR])
                return 2;
            if (!s[ST_BSY] && (!need_drq || s[ST_DRQ]))
                return 1;
            pcount = pcount + 24'd1;
            if (pcount >= limit)
                return 3;
            put(BUS_BRD, PORT_CMD, 16'h0);
            return 0;
        endfunction

        function void respond(logic [15:0] d);
            int   p;
            res_t r;
            case (ph)
                PH_PROBE:
                begin
                    if (d[7:0] == 8'h0)
                        close(OUT_NODEV);
                    else
                        start_wait(PH_WAIT_DRQ);
                end
                PH_WAIT_DRQ:
                begin
                    p = poll(d[7:0], 1);
                    if (p == 2)
                        close(OUT_DEVERR);
                    else if (p == 3)
                        close(OUT_TIMEOUT);
                    else if (p == 1)
                    begin
                        widx = 0;
                        if (op == REQ_WRITE)
                            ph = PH_WRITE_DATA;
                        else
                        begin
                            ph = PH_DATA_IN;
                            put(BUS_WRD, PORT_DATA, 16'h0);
                        end
                    end
                end
                PH_DATA_IN:
                begin
                    r = '0;
                    if (op == REQ_IDENT)
                    begin
                        if (widx == 60)
                            cap[15:0] = d;
                        if (widx == 61)
                            cap[31:16] = d;
                    end
                    else
                    begin
                        r.host_word_valid = 1'b1;
                        r.host_word = d;
                    end
                    widx++;
                    if (widx < SECTOR_WORDS)
                    begin
                        r.bus_op = BUS_WRD;
                        r.bus_port = PORT_DATA;
                    end
                    else
                    begin
                        r.done_res = 1'b1;
                        if (op == REQ_IDENT)
                        begin
                            rdy = (cap != 32'h0);
                            r.outcome = rdy ? OUT_OK : OUT_NODEV;
                        end
                        nout[r.outcome]++;
                        ph = PH_IDLE;
                    end
                    owed.push_back(r);
                end
                PH_DISCARD:
                    start_wait(PH_WAIT_DONE);
                PH_WAIT_DONE:
                begin
                    p = poll(d[7:0], 0);
                    if (p == 1)
                        close(OUT_OK);
                    else if (p == 2)
                        close(OUT_DEVERR);
                    else if (p == 3)
                        close(OUT_TIMEOUT);
                end
                default:
                    ;
            endcase
        endfunction

        // Called once for every accepted request transfer.
        function void note_input(logic [2:0] t, logic [31:0] l, logic [15:0] d);
            int n0;
            n0 = owed.size();
            if (t <= REQ_IDENT)
            begin
                if (ph == PH_IDLE)
                begin
                    op = t;
                    ncmd[t[1:0]]++;
                    if (t == REQ_READ || t == REQ_WRITE)
                    begin
                        if (!rdy || l >= cap || l > LBA28_MAX)
                            close(OUT_REJECT);
                        else
                        begin
                            put(BUS_BWR, PORT_DRIVE, {8'h0, DRIVE_LBA | {4'h0, l[27:24]}});
                            put(BUS_BWR, PORT_COUNT, 16'h1);
                            put(BUS_BWR, PORT_LBA0, {8'h0, l[7:0]});
                            put(BUS_BWR, PORT_LBA1, {8'h0, l[15:8]});
                            put(BUS_BWR, PORT_LBA2, {8'h0, l[23:16]});
                            put(BUS_BWR, PORT_CMD,
                                {8'h0, (t == REQ_READ) ? CMD_READ : CMD_WRITE});
                            start_wait(PH_WAIT_DRQ);
                        end
                    end
                    else if (t == REQ_FLUSH)
                    begin
                        if (!rdy)
                            close(OUT_REJECT);
                        else
                        begin
                            put(BUS_BWR, PORT_DRIVE, {8'h0, DRIVE_LBA});
                            put(BUS_BWR, PORT_CMD, {8'h0, CMD_FLUSH});
                            start_wait(PH_WAIT_DONE);
                        end
                    end
                    else
                    begin
                        rdy = 0;
                        cap = '0;
                        put(BUS_BWR, PORT_CTRL, 16'h2);
                        put(BUS_BWR, PORT_DRIVE, {8'h0, DRIVE_LBA});
                        put(BUS_BWR, PORT_COUNT, 16'h0);
                        put(BUS_BWR, PORT_LBA0, 16'h0);
                        put(BUS_BWR, PORT_LBA1, 16'h0);
                        put(BUS_BWR, PORT_LBA2, 16'h0);
                        put(BUS_BWR, PORT_CMD, {8'h0, CMD_IDENT});
                        ph = PH_PROBE;
                        put(BUS_BRD, PORT_CMD, 16'h0);
                    end
                end
            end
            else if (t == REQ_RESP)
                respond(d);
            else if (t == REQ_WWORD && ph == PH_WRITE_DATA)
            begin
                put(BUS_WWR, PORT_DATA, d);
                widx++;
                if (widx >= SECTOR_WORDS)
                begin
                    ph = PH_DISCARD;
                    put(BUS_BRD, PORT_CMD, 16'h0);
                end
            end
            if (owed.size() > n0)
                owed[owed.size() - 1].last = 1'b1;
        endfunction

        function string show(res_t r);
            return $sformatf("op=%0d port=%h data=%h hv=%0d hw=%h done=%0d out=%0d last=%0d",
                             r.bus_op, r.bus_port, r.bus_data, r.host_word_valid,
                             r.host_word, r.done_res, r.outcome, r.last);
        endfunction

        // Called once for every accepted result transfer.
        function void check_result(res_t got);
            res_t want;
            checked++;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: %s", show(got));
                return;
            end
            want = owed.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch at result %0d\n  expected %s\n  actual   %s",
                             checked, show(want), show(got));
            end
        endfunction
    endclass

    typedef struct {
        logic [2:0]  t;
        logic [31:0] l;
        logic [15:0] d;
    } req_item_t;

    typedef struct {
        logic [2:0]  t;
        logic [31:0] l;
        logic [31:0] c;
    } cmd_pick_t;

    logic clk;
    logic rst_n;

    ata_req_if req_ch ();
    ata_res_if res_ch ();
    ata_cfg_if cfg_ch ();

    ata_pio_sector_sequencer #(.SECTOR_WORDS(SECTOR_WORDS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    ata_scoreboard sb;
    cmd_pick_t     directed_cmds[$];
    logic [31:0]   cap_plan;
    bit            idling_on;
    bit            hold_request;
    int            cycle_count;
    int            cfg_settings;

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // A run that hangs is cut off here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Cycle limit reached with %0d results outstanding", sb.owed.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // The result side. It stalls in random bursts while idling is on, and once
    // holds off for a long stretch so that the job queue fills and the block
    // stops taking requests.
    initial
    begin : result_sink
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                stall = 400;
            end
            else if (stall == 0 && idling_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 13);
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Every transfer on the result channel goes to the scoreboard.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.bus_op = res_ch.bus_op;
            got.bus_port = res_ch.bus_port;
            got.bus_data = res_ch.bus_data;
            got.host_word_valid = res_ch.host_word_valid;
            got.host_word = res_ch.host_word;
            got.done_res = res_ch.done_res;
            got.outcome = res_ch.outcome;
            got.last = res_ch.last;
            sb.check_result(got);
        end
    end

    // A status byte with a mix of ready, busy, missing data-request, error and
    // fully random values. Upper bits of the word are random throughout.
    function automatic logic [15:0] pick_status();
        logic [15:0] s;
        s = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: s = (s & 16'hFF76) | 16'h0008;
            5, 6:          s = (s & 16'hFFFE) | 16'h0080;
            7:             s = (s & 16'hFF76);
            8:             s = s | 16'h0001;
            default:       ;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] pick_capacity();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'h1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h1000_0000;
            4:       return 32'h0001_0000;
            5:       return $urandom;
            default: return $urandom_range(2, 1000);
        endcase
    endfunction

    function automatic logic [31:0] pick_lba();
        logic [31:0] c;
        c = sb.cap;
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return c - 32'd1;
            2:       return c;
            3:       return LBA28_MAX;
            4:       return LBA28_MAX + 32'd1;
            5:       return 32'hFFFF_FFFF;
            6:       return $urandom;
            default: return (c == 0) ? 32'h0 : ($urandom % c);
        endcase
    endfunction

    // Picks the next request from the model's phase: a command when idle, a
    // status byte while polling, a data word during a transfer. Some items are
    // noise: stray responses, commands while busy, unused request codes.
    function automatic req_item_t next_item(bit noise);
        req_item_t it;
        cmd_pick_t pick;
        it.t = REQ_RESP;
        it.l = $urandom;
        it.d = 16'($urandom);
        if (noise && $urandom_range(0, 19) == 0)
        begin
            it.t = 3'($urandom_range(0, 7));
            return it;
        end
        case (sb.ph)
            PH_IDLE:
            begin
                if (directed_cmds.size() > 0)
                begin
                    pick = directed_cmds.pop_front();
                    it.t = pick.t;
                    it.l = pick.l;
                    if (pick.t == REQ_IDENT)
                        cap_plan = pick.c;
                end
                else if (!sb.rdy ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0))
                begin
                    it.t = REQ_IDENT;
                    cap_plan = pick_capacity();
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    it.t = REQ_READ;
                        2, 3:    it.t = REQ_WRITE;
                        default: it.t = REQ_FLUSH;
                    endcase
                    it.l = pick_lba();
                end
            end
            PH_PROBE:
            begin
                if ($urandom_range(0, 4) == 0)
                    it.d = {8'($urandom_range(0, 255)), 8'h00};
                else if (it.d[7:0] == 8'h0)
                    it.d[2] = 1'b1;
            end
            PH_WAIT_DRQ, PH_WAIT_DONE, PH_DISCARD:
                it.d = pick_status();
            PH_DATA_IN:
            begin
                if (sb.op == REQ_IDENT && sb.widx == 60)
                    it.d = cap_plan[15:0];
                else if (sb.op == REQ_IDENT && sb.widx == 61)
                    it.d = cap_plan[31:16];
            end
            PH_WRITE_DATA:
                it.t = REQ_WWORD;
            default:
                ;
        endcase
        return it;
    endfunction

    // One request transfer; returns at the edge where it was taken. The valid
    // line stays high into the next item unless a gap follows.
    task automatic send_item(req_item_t it);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= it.t;
        req_ch.lba <= it.l;
        req_ch.data <= it.d;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_input(it.t, it.l, it.d);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Sends n items, not counting the bulk data words, then finishes the
    // command in flight so that the block ends up idle.
    task automatic run_items(int n);
        req_item_t it;
        int        counted;
        counted = 0;
        while (counted < n || directed_cmds.size() > 0)
        begin
            if (sb.ph != PH_DATA_IN && sb.ph != PH_WRITE_DATA)
                counted++;
            it = next_item(1);
            send_item(it);
        end
        while (sb.ph != PH_IDLE)
        begin
            it = next_item(0);
            send_item(it);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.owed.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The register is only written once the block has gone quiet.
    task automatic write_limit(logic [23:0] v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.poll_limit <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.limit = v;
        cfg_settings++;
    endtask

    task automatic add_cmd(logic [2:0] t, logic [31:0] l, logic [31:0] c);
        cmd_pick_t p;
        p.t = t;
        p.l = l;
        p.c = c;
        directed_cmds.push_back(p);
    endtask

    initial
    begin : stimulus
        logic [23:0] limits[6];
        sb = new();
        idling_on = 1;
        hold_request = 0;
        cycle_count = 0;
        cfg_settings = 0;
        cap_plan = '0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_READ;
        req_ch.lba <= '0;
        req_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.poll_limit <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: commands before any disk is known, an identify that finds
        // no capacity, one that reports the full 32-bit range, then the sector
        // number extremes around the LBA28 limit, a write and a flush, and the
        // two unused request codes.
        add_cmd(REQ_READ, 32'h0, 32'h0);
        add_cmd(REQ_WRITE, 32'h0, 32'h0);
        add_cmd(REQ_FLUSH, 32'h0, 32'h0);
        add_cmd(REQ_IDENT, 32'h0, 32'h0);
        add_cmd(REQ_IDENT, 32'h0, 32'hFFFF_FFFF);
        add_cmd(REQ_READ, 32'hFFFF_FFFF, 32'h0);
        add_cmd(REQ_READ, LBA28_MAX + 32'd1, 32'h0);
        add_cmd(REQ_READ, LBA28_MAX, 32'h0);
        add_cmd(REQ_WRITE, 32'h0, 32'h0);
        add_cmd(REQ_FLUSH, 32'h0, 32'h0);
        add_cmd(3'd6, 32'h0, 32'h0);
        add_cmd(3'd7, 32'h0, 32'h0);
        run_items(12);

        // Random phases over several poll limits: the widest, a single poll,
        // zero (first failed poll times out), small ones and the reset value.
        limits[0] = 24'hFF_FFFF;
        limits[1] = 24'd1;
        limits[2] = 24'd0;
        limits[3] = 24'($urandom_range(2, 6));
        limits[4] = 24'($urandom_range(1, 20));
        limits[5] = POLL_RESET;
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            if (i == 2)
                hold_request = 1;
            if (i == 5)
                idling_on = 0;
            run_items(50);
        end

        wait_drained();
        $display("Run covered %0d reads, %0d writes, %0d flushes, %0d identifies, %0d limits",
                 sb.ncmd[REQ_READ], sb.ncmd[REQ_WRITE], sb.ncmd[REQ_FLUSH],
                 sb.ncmd[REQ_IDENT], cfg_settings + 1);
        $display("Outcomes ok %0d, rejected %0d, error %0d, timeout %0d, no device %0d; %0d checked",
                 sb.nout[OUT_OK], sb.nout[OUT_REJECT], sb.nout[OUT_DEVERR],
                 sb.nout[OUT_TIMEOUT], sb.nout[OUT_NODEV], sb.checked);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("PASSED: all results match");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.owed.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
